FILE: rtl/meo_pkg.sv
// Package for the midpoint ellipse outline unit: field widths, controller
// states, datapath commands and the control/status structs.
// No dependencies; every other file of the block refers to it by scoped names.
package meo_pkg;

    // Fixed field widths of the channels
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 12;
    localparam int PIXEL_W  = 17;
    localparam int COLOR_W  = 32;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_MUL_RY,
        ST_INIT_D,
        ST_MUL_P2,
        ST_SET_P2,
        ST_EVAL,
        ST_R2_SS,
        ST_R2_BT,
        ST_R2_AT,
        ST_R2_ADD,
        ST_R2_TRUNC,
        ST_NOPIX
    } ctrl_state_t;

    // Operand pairs of the shared multiplier
    typedef enum logic [3:0] {
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_A2_RY,
        MUL_B2_X1,
        MUL_A2_Y21,
        MUL_T_T,
        MUL_S_S,
        MUL_B2_TMP,
        MUL_A2_TMP
    } mul_sel_t;

    // Register updates of the datapath
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_A2,
        OP_SET_B2,
        OP_INIT_D,
        OP_SET_P1,
        OP_SET_P2,
        OP_R1_STEP,
        OP_ENTER_R2,
        OP_SET_TMP,
        OP_SET_TMP_SQB,
        OP_SET_D,
        OP_ADD_D4,
        OP_TRUNC_D,
        OP_R2_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic region_two;
        logic slope_ok;
        logic d_nonneg;
        logic y_le_zero;
    } dp_status_t;

    typedef struct packed {
        logic launch;
        logic nopix;
        logic two_quads;
        logic done;
    } emit_cmd_t;

endpackage

FILE: rtl/meo_in_if.sv
// Input channel of the midpoint ellipse outline unit: valid/ready plus one item.
// Depends on meo_pkg for the field widths.
interface meo_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [meo_pkg::COORD_W-1:0]  center_x;
    logic signed [meo_pkg::COORD_W-1:0]  center_y;
    logic        [meo_pkg::RADIUS_W-1:0] radius_x;
    logic        [meo_pkg::RADIUS_W-1:0] radius_y;
    logic        [meo_pkg::COLOR_W-1:0]  pixel_color;

    modport source
    (
        output valid, func, center_x, center_y, radius_x, radius_y, pixel_color,
        input  ready
    );

    modport sink
    (
        input  valid, func, center_x, center_y, radius_x, radius_y, pixel_color,
        output ready
    );
endinterface

FILE: rtl/meo_out_if.sv
// Output channel of the midpoint ellipse outline unit: valid/ready plus one pixel.
// Depends on meo_pkg for the field widths.
interface meo_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [meo_pkg::PIXEL_W-1:0] pixel_x;
    logic signed [meo_pkg::PIXEL_W-1:0] pixel_y;
    logic        [meo_pkg::COLOR_W-1:0] out_color;
    logic                               no_pixel;
    logic                               last_of_step;
    logic                               ellipse_done;

    modport source
    (
        output valid, pixel_x, pixel_y, out_color, no_pixel, last_of_step, ellipse_done,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_x, pixel_y, out_color, no_pixel, last_of_step, ellipse_done,
        output ready
    );
endinterface

FILE: rtl/midpoint_ellipse_outline_unit.sv
// Top level of the midpoint ellipse outline rasterizer.
// Depends on meo_pkg, meo_in_if, meo_out_if, meo_ctrl, meo_datapath, meo_emit.
//
// A start item (func = 0) loads center, radii and color, then squares the
// radii and sets up the decision value; it yields no pixel. A step item
// (func = 1) is evaluated, and the one step that crosses from region 1
// into region 2 also recomputes the decision value through the single
// shared multiplier. Its 4 or 8 pixels then leave one per cycle through
// the output register while the output is ready; the next item is taken
// while the previous pixels still drain. A step with no ellipse in
// progress gives one result flagged no_pixel. The last pixel of each step
// carries last_of_step, and the last pixel of the ellipse also carries
// ellipse_done. Radii use their low RADIUS_BITS bits.
module midpoint_ellipse_outline_unit #(
    parameter int RADIUS_BITS = 12
)
(
    input  logic     clk,
    input  logic     rst_n,
    meo_in_if.sink   req,
    meo_out_if.source pix
);

    localparam int RB = (RADIUS_BITS < meo_pkg::RADIUS_W) ? RADIUS_BITS : meo_pkg::RADIUS_W;
    localparam int XW = RB + 1;

    meo_pkg::dp_cmd_t    dp_cmd;
    meo_pkg::dp_status_t dp_status;
    meo_pkg::emit_cmd_t  emit_cmd;
    logic                emit_busy;
    logic                in_ready;

    logic [XW-1:0]                      cur_x;
    logic signed [XW-1:0]               cur_y;
    logic signed [meo_pkg::COORD_W-1:0] origin_x;
    logic signed [meo_pkg::COORD_W-1:0] origin_y;
    logic [meo_pkg::COLOR_W-1:0]        held_color;

    assign req.ready = in_ready;

    // Sequence the iteration
    meo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .emit_busy (emit_busy),
        .dp_cmd    (dp_cmd),
        .emit_cmd  (emit_cmd)
    );

    // Hold the ellipse state and do the arithmetic
    meo_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .center_x    (req.center_x),
        .center_y    (req.center_y),
        .radius_x    (req.radius_x),
        .radius_y    (req.radius_y),
        .pixel_color (req.pixel_color),
        .dp_status   (dp_status),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .held_color  (held_color)
    );

    // Expand quads into pixel transfers
    meo_emit #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit_cmd (emit_cmd),
        .dx       (cur_x),
        .dy       (cur_y),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .color    (held_color),
        .busy     (emit_busy),
        .pix      (pix)
    );

endmodule

FILE: rtl/meo_ctrl.sv
// Controller of the midpoint ellipse outline unit: sequences the shared
// multiplier and the decision updates, and launches the pixel emitter.
// Depends on meo_pkg for states, commands and status structs.
module meo_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_ready,
    input  meo_pkg::dp_status_t dp_status,
    input  logic                emit_busy,
    output meo_pkg::dp_cmd_t    dp_cmd,
    output meo_pkg::emit_cmd_t  emit_cmd
);

    meo_pkg::ctrl_state_t state_reg;
    meo_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= meo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next         = state_reg;
        in_ready           = 1'b0;
        dp_cmd.op          = meo_pkg::OP_NONE;
        dp_cmd.mul_sel     = meo_pkg::MUL_B2_X1;
        emit_cmd.launch    = 1'b0;
        emit_cmd.nopix     = 1'b0;
        emit_cmd.two_quads = 1'b0;
        emit_cmd.done      = 1'b0;

        unique case (state_reg)
            meo_pkg::ST_IDLE:
            begin
                // Keep b2*(x+1) ready in the product register while waiting
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_func)
                    begin
                        dp_cmd.op  = meo_pkg::OP_LOAD;
                        state_next = meo_pkg::ST_SQ_RX;
                    end
                    else if (dp_status.active)
                    begin
                        state_next = meo_pkg::ST_MUL_P2;
                    end
                    else
                    begin
                        state_next = meo_pkg::ST_NOPIX;
                    end
                end
            end

            meo_pkg::ST_SQ_RX:
            begin
                dp_cmd.mul_sel = meo_pkg::MUL_RX_RX;
                state_next     = meo_pkg::ST_SQ_RY;
            end

            meo_pkg::ST_SQ_RY:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_A2;
                dp_cmd.mul_sel = meo_pkg::MUL_RY_RY;
                state_next     = meo_pkg::ST_MUL_RY;
            end

            meo_pkg::ST_MUL_RY:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_B2;
                dp_cmd.mul_sel = meo_pkg::MUL_A2_RY;
                state_next     = meo_pkg::ST_INIT_D;
            end

            meo_pkg::ST_INIT_D:
            begin
                dp_cmd.op  = meo_pkg::OP_INIT_D;
                state_next = meo_pkg::ST_IDLE;
            end

            meo_pkg::ST_MUL_P2:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_P1;
                dp_cmd.mul_sel = meo_pkg::MUL_A2_Y21;
                state_next     = meo_pkg::ST_SET_P2;
            end

            meo_pkg::ST_SET_P2:
            begin
                dp_cmd.op  = meo_pkg::OP_SET_P2;
                state_next = meo_pkg::ST_EVAL;
            end

            meo_pkg::ST_EVAL:
            begin
                priority if (!dp_status.region_two && !dp_status.slope_ok)
                begin
                    // Slope test failed: switch to region 2, start (2x+1)^2
                    dp_cmd.op      = meo_pkg::OP_ENTER_R2;
                    dp_cmd.mul_sel = meo_pkg::MUL_T_T;
                    state_next     = meo_pkg::ST_R2_SS;
                end
                else if (emit_busy)
                begin
                    state_next = meo_pkg::ST_EVAL;
                end
                else if (!dp_status.region_two)
                begin
                    dp_cmd.op          = meo_pkg::OP_R1_STEP;
                    emit_cmd.launch    = 1'b1;
                    emit_cmd.two_quads = dp_status.d_nonneg;
                    state_next         = meo_pkg::ST_IDLE;
                end
                else
                begin
                    dp_cmd.op       = meo_pkg::OP_R2_STEP;
                    emit_cmd.launch = 1'b1;
                    emit_cmd.done   = dp_status.y_le_zero;
                    state_next      = meo_pkg::ST_IDLE;
                end
            end

            meo_pkg::ST_R2_SS:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_TMP;
                dp_cmd.mul_sel = meo_pkg::MUL_S_S;
                state_next     = meo_pkg::ST_R2_BT;
            end

            meo_pkg::ST_R2_BT:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_TMP_SQB;
                dp_cmd.mul_sel = meo_pkg::MUL_B2_TMP;
                state_next     = meo_pkg::ST_R2_AT;
            end

            meo_pkg::ST_R2_AT:
            begin
                dp_cmd.op      = meo_pkg::OP_SET_D;
                dp_cmd.mul_sel = meo_pkg::MUL_A2_TMP;
                state_next     = meo_pkg::ST_R2_ADD;
            end

            meo_pkg::ST_R2_ADD:
            begin
                dp_cmd.op  = meo_pkg::OP_ADD_D4;
                state_next = meo_pkg::ST_R2_TRUNC;
            end

            meo_pkg::ST_R2_TRUNC:
            begin
                dp_cmd.op  = meo_pkg::OP_TRUNC_D;
                state_next = meo_pkg::ST_EVAL;
            end

            meo_pkg::ST_NOPIX:
            begin
                if (!emit_busy)
                begin
                    emit_cmd.launch = 1'b1;
                    emit_cmd.nopix  = 1'b1;
                    state_next      = meo_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = meo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/meo_datapath.sv
// Datapath of the midpoint ellipse outline unit: ellipse state, one shared
// registered multiplier and the decision-variable adder.
// Depends on meo_pkg for widths, command and status types.
module meo_datapath #(
    parameter int RADIUS_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  meo_pkg::dp_cmd_t                    dp_cmd,
    input  logic signed [meo_pkg::COORD_W-1:0]  center_x,
    input  logic signed [meo_pkg::COORD_W-1:0]  center_y,
    input  logic        [meo_pkg::RADIUS_W-1:0] radius_x,
    input  logic        [meo_pkg::RADIUS_W-1:0] radius_y,
    input  logic        [meo_pkg::COLOR_W-1:0]  pixel_color,
    output meo_pkg::dp_status_t                 dp_status,
    output logic [((RADIUS_BITS < meo_pkg::RADIUS_W) ?
                   RADIUS_BITS : meo_pkg::RADIUS_W):0] cur_x,
    output logic signed [((RADIUS_BITS < meo_pkg::RADIUS_W) ?
                   RADIUS_BITS : meo_pkg::RADIUS_W):0] cur_y,
    output logic signed [meo_pkg::COORD_W-1:0]  origin_x,
    output logic signed [meo_pkg::COORD_W-1:0]  origin_y,
    output logic        [meo_pkg::COLOR_W-1:0]  held_color
);

    localparam int RB = (RADIUS_BITS < meo_pkg::RADIUS_W) ? RADIUS_BITS : meo_pkg::RADIUS_W;
    localparam int XW = RB + 1;
    localparam int SW = 2 * RB;
    localparam int OW = 2 * RB + 4;
    localparam int PW = 2 * OW;
    localparam int DW = 4 * RB + 6;

    localparam logic signed [OW-1:0] ONE_O   = OW'(1);
    localparam logic signed [DW-1:0] THREE_D = DW'(3);

    logic        [RB-1:0]              rx_reg;
    logic        [RB-1:0]              ry_reg;
    logic signed [meo_pkg::COORD_W-1:0] ox_reg;
    logic signed [meo_pkg::COORD_W-1:0] oy_reg;
    logic        [meo_pkg::COLOR_W-1:0] color_reg;
    logic        [XW-1:0]              x_reg;
    logic signed [XW-1:0]              y_reg;
    logic        [SW-1:0]              a2_reg;
    logic        [SW-1:0]              b2_reg;
    logic signed [PW-1:0]              prod_reg;
    logic signed [DW-1:0]              d_reg;
    logic signed [DW-1:0]              p1_reg;
    logic signed [DW-1:0]              p2_reg;
    logic signed [OW-1:0]              tmp_reg;
    logic                              active_reg;
    logic                              region2_reg;

    logic signed [OW-1:0] xs;
    logic signed [OW-1:0] ys;
    logic signed [OW-1:0] mul_a;
    logic signed [OW-1:0] mul_b;
    logic signed [DW-1:0] prod_d;
    logic signed [DW-1:0] a2_d;
    logic signed [DW-1:0] b2_d;
    logic signed [DW-1:0] d_trunc;
    logic        [RB-1:0] rx_in;
    logic        [RB-1:0] ry_in;

    assign rx_in  = radius_x[RB-1:0];
    assign ry_in  = radius_y[RB-1:0];
    assign xs     = $signed({{(OW-XW){1'b0}}, x_reg});
    assign ys     = {{(OW-XW){y_reg[XW-1]}}, y_reg};
    assign prod_d = $signed(prod_reg[DW-1:0]);
    assign a2_d   = $signed({{(DW-SW){1'b0}}, a2_reg});
    assign b2_d   = $signed({{(DW-SW){1'b0}}, b2_reg});

    // Truncate d/4 toward zero
    assign d_trunc = d_reg[DW-1] ? ((d_reg + THREE_D) >>> 2) : (d_reg >>> 2);

    // Select multiplier operands
    always_comb
    begin
        mul_a = $signed({{(OW-SW){1'b0}}, b2_reg});
        mul_b = xs + ONE_O;
        unique case (dp_cmd.mul_sel)
            meo_pkg::MUL_RX_RX:
            begin
                mul_a = $signed({{(OW-RB){1'b0}}, rx_reg});
                mul_b = $signed({{(OW-RB){1'b0}}, rx_reg});
            end
            meo_pkg::MUL_RY_RY:
            begin
                mul_a = $signed({{(OW-RB){1'b0}}, ry_reg});
                mul_b = $signed({{(OW-RB){1'b0}}, ry_reg});
            end
            meo_pkg::MUL_A2_RY:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, a2_reg});
                mul_b = $signed({{(OW-RB){1'b0}}, ry_reg});
            end
            meo_pkg::MUL_B2_X1:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, b2_reg});
                mul_b = xs + ONE_O;
            end
            meo_pkg::MUL_A2_Y21:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, a2_reg});
                mul_b = (ys <<< 1) - ONE_O;
            end
            meo_pkg::MUL_T_T:
            begin
                mul_a = (xs <<< 1) + ONE_O;
                mul_b = (xs <<< 1) + ONE_O;
            end
            meo_pkg::MUL_S_S:
            begin
                mul_a = ys - ONE_O;
                mul_b = ys - ONE_O;
            end
            meo_pkg::MUL_B2_TMP:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, b2_reg});
                mul_b = tmp_reg;
            end
            meo_pkg::MUL_A2_TMP:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, a2_reg});
                mul_b = tmp_reg;
            end
            default:
            begin
                mul_a = $signed({{(OW-SW){1'b0}}, b2_reg});
                mul_b = xs + ONE_O;
            end
        endcase
    end

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Control flags of the ellipse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            region2_reg <= 1'b0;
        end
        else
        begin
            unique case (dp_cmd.op)
                meo_pkg::OP_LOAD:
                begin
                    active_reg  <= (rx_in != '0) && (ry_in != '0);
                    region2_reg <= 1'b0;
                end
                meo_pkg::OP_ENTER_R2:
                begin
                    region2_reg <= 1'b1;
                end
                meo_pkg::OP_R2_STEP:
                begin
                    if (dp_status.y_le_zero)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                default:
                begin
                    active_reg  <= active_reg;
                end
            endcase
        end
    end

    // Payload registers: geometry, squares, products and the decision value
    always_ff @(posedge clk)
    begin
        unique case (dp_cmd.op)
            meo_pkg::OP_LOAD:
            begin
                rx_reg    <= rx_in;
                ry_reg    <= ry_in;
                ox_reg    <= center_x;
                oy_reg    <= center_y;
                color_reg <= pixel_color;
                x_reg     <= '0;
                y_reg     <= $signed({1'b0, ry_in});
            end
            meo_pkg::OP_SET_A2:
            begin
                a2_reg <= prod_reg[SW-1:0];
            end
            meo_pkg::OP_SET_B2:
            begin
                b2_reg <= prod_reg[SW-1:0];
            end
            meo_pkg::OP_INIT_D:
            begin
                d_reg <= b2_d - prod_d + (a2_d >>> 2);
            end
            meo_pkg::OP_SET_P1:
            begin
                p1_reg <= prod_d;
            end
            meo_pkg::OP_SET_P2:
            begin
                p2_reg <= prod_d;
            end
            meo_pkg::OP_R1_STEP:
            begin
                // d += b2*(2x+3), and on a row step also -= a2*(2y-2)
                if (d_reg[DW-1])
                begin
                    d_reg <= d_reg + (p1_reg <<< 1) + b2_d;
                end
                else
                begin
                    d_reg <= d_reg + (p1_reg <<< 1) + b2_d - p2_reg + a2_d;
                    y_reg <= y_reg - XW'(1);
                end
                x_reg <= x_reg + XW'(1);
            end
            meo_pkg::OP_SET_TMP:
            begin
                tmp_reg <= $signed(prod_reg[OW-1:0]);
            end
            meo_pkg::OP_SET_TMP_SQB:
            begin
                tmp_reg <= $signed(prod_reg[OW-1:0]) - $signed({{(OW-SW){1'b0}}, b2_reg});
            end
            meo_pkg::OP_SET_D:
            begin
                d_reg <= prod_d;
            end
            meo_pkg::OP_ADD_D4:
            begin
                d_reg <= d_reg + (prod_d <<< 2);
            end
            meo_pkg::OP_TRUNC_D:
            begin
                d_reg <= d_trunc;
            end
            meo_pkg::OP_R2_STEP:
            begin
                // d += a2*(3-2y), plus 2*b2*(x+1) when x advances
                if (!d_reg[DW-1] && (d_reg != '0))
                begin
                    d_reg <= d_reg + (a2_d <<< 1) - p2_reg;
                end
                else
                begin
                    d_reg <= d_reg + (p1_reg <<< 1) + (a2_d <<< 1) - p2_reg;
                    x_reg <= x_reg + XW'(1);
                end
                y_reg <= y_reg - XW'(1);
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    // Status toward the controller
    assign dp_status.active     = active_reg;
    assign dp_status.region_two = region2_reg;
    assign dp_status.slope_ok   = (p1_reg <<< 1) < p2_reg;
    assign dp_status.d_nonneg   = !d_reg[DW-1];
    assign dp_status.y_le_zero  = y_reg[XW-1] || (y_reg == '0);

    assign cur_x      = x_reg;
    assign cur_y      = y_reg;
    assign origin_x   = ox_reg;
    assign origin_y   = oy_reg;
    assign held_color = color_reg;

endmodule

FILE: rtl/meo_emit.sv
// Pixel emitter of the midpoint ellipse outline unit: expands one or two
// mirrored quads into single pixels and holds them in the output register.
// Depends on meo_pkg and meo_out_if.
module meo_emit #(
    parameter int RADIUS_BITS = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  meo_pkg::emit_cmd_t                 emit_cmd,
    input  logic [((RADIUS_BITS < meo_pkg::RADIUS_W) ?
                   RADIUS_BITS : meo_pkg::RADIUS_W):0] dx,
    input  logic signed [((RADIUS_BITS < meo_pkg::RADIUS_W) ?
                   RADIUS_BITS : meo_pkg::RADIUS_W):0] dy,
    input  logic signed [meo_pkg::COORD_W-1:0] origin_x,
    input  logic signed [meo_pkg::COORD_W-1:0] origin_y,
    input  logic        [meo_pkg::COLOR_W-1:0] color,
    output logic                               busy,
    meo_out_if.source                          pix
);

    localparam int RB = (RADIUS_BITS < meo_pkg::RADIUS_W) ? RADIUS_BITS : meo_pkg::RADIUS_W;
    localparam int XW = RB + 1;
    localparam int PXW = meo_pkg::PIXEL_W;

    logic                               busy_reg;
    logic [1:0]                         idx_reg;
    logic                               second_reg;
    logic                               nopix_reg;
    logic                               done_reg;
    logic [XW-1:0]                      dx_reg;
    logic signed [XW-1:0]               dy_reg;
    logic signed [meo_pkg::COORD_W-1:0] ox_reg;
    logic signed [meo_pkg::COORD_W-1:0] oy_reg;
    logic [meo_pkg::COLOR_W-1:0]        color_reg;

    logic                               out_valid_reg;
    logic signed [PXW-1:0]              px_reg;
    logic signed [PXW-1:0]              py_reg;
    logic [meo_pkg::COLOR_W-1:0]        ocolor_reg;
    logic                               onopix_reg;
    logic                               olast_reg;
    logic                               odone_reg;

    logic                  slot_free;
    logic                  emit_now;
    logic                  quad_end;
    logic signed [PXW-1:0] dx_e;
    logic signed [PXW-1:0] dy_e;
    logic signed [PXW-1:0] ox_e;
    logic signed [PXW-1:0] oy_e;
    logic signed [PXW-1:0] px_next;
    logic signed [PXW-1:0] py_next;

    assign slot_free = !out_valid_reg || pix.ready;
    assign emit_now  = busy_reg && slot_free;
    assign quad_end  = (idx_reg == 2'd3);

    // Mirror the current point around the origin; bit 0 flips x, bit 1 flips y
    assign dx_e    = $signed({{(PXW-XW){1'b0}}, dx_reg});
    assign dy_e    = {{(PXW-XW){dy_reg[XW-1]}}, dy_reg};
    assign ox_e    = {ox_reg[meo_pkg::COORD_W-1], ox_reg};
    assign oy_e    = {oy_reg[meo_pkg::COORD_W-1], oy_reg};
    assign px_next = idx_reg[0] ? (ox_e - dx_e) : (ox_e + dx_e);
    assign py_next = idx_reg[1] ? (oy_e - dy_e) : (oy_e + dy_e);

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            second_reg    <= 1'b0;
            nopix_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (slot_free)
            begin
                out_valid_reg <= busy_reg;
            end

            priority if (emit_cmd.launch && !busy_reg)
            begin
                busy_reg   <= 1'b1;
                idx_reg    <= 2'd0;
                second_reg <= emit_cmd.two_quads;
                nopix_reg  <= emit_cmd.nopix;
                done_reg   <= emit_cmd.done;
            end
            else if (emit_now)
            begin
                if (nopix_reg)
                begin
                    busy_reg <= 1'b0;
                end
                else if (quad_end)
                begin
                    idx_reg <= 2'd0;
                    if (second_reg)
                    begin
                        second_reg <= 1'b0;
                    end
                    else
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            else
            begin
                busy_reg <= busy_reg;
            end
        end
    end

    // Latch the point and origin on launch; step one row inward for the second quad
    always_ff @(posedge clk)
    begin
        if (emit_cmd.launch && !busy_reg)
        begin
            dx_reg    <= dx;
            dy_reg    <= dy;
            ox_reg    <= origin_x;
            oy_reg    <= origin_y;
            color_reg <= color;
        end
        else if (emit_now && quad_end && second_reg)
        begin
            dy_reg <= dy_reg - XW'(1);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            if (nopix_reg)
            begin
                px_reg     <= '0;
                py_reg     <= '0;
                ocolor_reg <= '0;
                onopix_reg <= 1'b1;
                olast_reg  <= 1'b1;
                odone_reg  <= 1'b0;
            end
            else
            begin
                px_reg     <= px_next;
                py_reg     <= py_next;
                ocolor_reg <= color_reg;
                onopix_reg <= 1'b0;
                olast_reg  <= quad_end && !second_reg;
                odone_reg  <= quad_end && !second_reg && done_reg;
            end
        end
    end

    assign busy             = busy_reg;
    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = px_reg;
    assign pix.pixel_y      = py_reg;
    assign pix.out_color    = ocolor_reg;
    assign pix.no_pixel     = onopix_reg;
    assign pix.last_of_step = olast_reg;
    assign pix.ellipse_done = odone_reg;

endmodule
